// ===== src/ddt_pkg.sv =====
// Shared widths, field layout and sequencer states for the drawdown tracker.
package ddt_pkg;

  localparam int VALUE_WIDTH   = 48;
  localparam int FRACTION_BITS = 16;
  localparam int DAY_W         = 32;
  localparam int RATIO_W       = 18;

  localparam int IN_USED_W  = DAY_W + VALUE_WIDTH;
  localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W = 3 * VALUE_WIDTH + RATIO_W + 6 * DAY_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DROP,
    ST_DIV,
    ST_DUR,
    ST_FIN
  } state_t;

endpackage

// ===== src/ddt_div.sv =====
// Restoring divider: drop over peak magnitude, one quotient bit per cycle, saturating.
module ddt_div #(
  parameter int FRACTION_BITS = ddt_pkg::FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [ddt_pkg::VALUE_WIDTH-1:0]    drop,
  input  logic [ddt_pkg::VALUE_WIDTH-1:0]    mag,
  output logic                               done,
  output logic [ddt_pkg::RATIO_W-1:0]        ratio
);

  localparam int VW    = ddt_pkg::VALUE_WIDTH;
  localparam int QW    = ddt_pkg::RATIO_W;
  localparam int NW    = VW + FRACTION_BITS;
  localparam int LW    = VW + QW;
  localparam int CW    = (NW > LW) ? NW : LW;
  localparam int CNT_W = $clog2(QW);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [VW-1:0]     rem_r;
  logic [VW-1:0]     mag_r;
  logic [QW-1:0]     nbits_r;
  logic [QW-1:0]     q_r;

  logic [CW-1:0]     num_ext;
  logic [CW-1:0]     lim_ext;
  logic              sat;
  logic [VW+1:0]     diff;
  logic              take;

  // Scaled numerator and the bound at which the quotient no longer fits.
  assign num_ext = CW'(drop) << FRACTION_BITS;
  assign lim_ext = CW'(mag) << QW;
  assign sat     = (num_ext >= lim_ext);

  assign diff = {1'b0, rem_r, nbits_r[QW-1]} - {2'b00, mag_r};
  assign take = ~diff[VW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        mag_r   <= mag;
        rem_r   <= VW'(num_ext >> QW);
        nbits_r <= num_ext[QW-1:0];
        cnt_r   <= '0;
        if (sat) begin
          q_r    <= '1;
          done_r <= 1'b1;
        end else begin
          q_r    <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r   <= take ? diff[VW-1:0] : {rem_r[VW-2:0], nbits_r[QW-1]};
        q_r     <= {q_r[QW-2:0], take};
        nbits_r <= {nbits_r[QW-2:0], 1'b0};
        cnt_r   <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign ratio = q_r;

endmodule

// ===== src/drawdown_tracker_core.sv =====
// Top level of the drawdown tracker: sequencer, tracker state and stream ports.
//
//  channel | dir | tdata fields (lsb first)            | tuser        | tlast
//  in_     | in  | sample_day, equity_value            | start_series | -
//  out_    | out | max_drawdown .. peak_day (10 flds)  | -            | -
//
// An item that starts a series or leaves the records alone goes from ST_EVAL
// straight to ST_FIN; a new peak passes through ST_DUR, a non-record trough
// through ST_DROP and ST_DUR, and a record drop through ST_DROP, ST_DIV and
// ST_DUR; the divider retires one quotient bit a cycle unless it saturates.
// in_tready is high only while the sequencer idles. The finished result sits
// in an output register, so the next item is taken while it waits; a second
// result stalls in the final state until the first one is taken.
// Reset (rst_n low at a clock edge) clears the sequencer and the started
// flag; the first item after reset always reloads every record.
module drawdown_tracker_core #(
  parameter int FRACTION_BITS = ddt_pkg::FRACTION_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] sample_day, [79:32] equity_value
  input  logic [ddt_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] start_series
  input  logic                            in_tuser,

  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [47:0] max_drawdown, [65:48] max_drawdown_ratio, [97:66] max_dd_begin_day,
  // [129:98] max_dd_end_day, [161:130] longest_duration,
  // [193:162] longest_begin_day, [225:194] longest_end_day,
  // [273:226] peak_value, [321:274] trough_value, [353:322] peak_day,
  // [359:354] zero
  output logic [ddt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int VW   = ddt_pkg::VALUE_WIDTH;
  localparam int DW   = ddt_pkg::DAY_W;
  localparam int QW   = ddt_pkg::RATIO_W;
  localparam int PADW = ddt_pkg::OUT_DATA_W - ddt_pkg::OUT_USED_W;

  ddt_pkg::state_t state_r, state_nxt;

  // Latched input item
  logic                  start_in_r;
  logic [DW-1:0]         day_in_r;
  logic signed [VW-1:0]  eq_in_r;

  // Tracker state
  logic                  started_r;
  logic signed [VW-1:0]  high_r;
  logic signed [VW-1:0]  low_r;
  logic [DW-1:0]         hday_r;
  logic [VW-1:0]         wdrop_r;
  logic [QW-1:0]         wratio_r;
  logic [DW-1:0]         wbeg_r;
  logic [DW-1:0]         wend_r;
  logic [DW-1:0]         ldays_r;
  logic [DW-1:0]         lbeg_r;
  logic [DW-1:0]         lend_r;

  // Work registers
  logic                  peak_case_r;
  logic [VW-1:0]         drop_r;
  logic [VW-1:0]         mag_r;

  logic                        out_valid_r;
  logic [ddt_pkg::OUT_DATA_W-1:0] out_data_r;

  // Sequencer decodes
  logic        first_item;
  logic        ge_peak;
  logic        lt_trough;
  logic        new_worst;
  logic [DW-1:0] dur;
  logic        longer;
  logic        out_free;

  // Strobes
  logic        accept;
  logic        do_init;
  logic        do_peak_run;
  logic        do_low;
  logic        do_worst;
  logic        do_ratio;
  logic        do_dur;
  logic        do_out;

  logic              div_done;
  logic [QW-1:0]     div_ratio;

  assign first_item = start_in_r | ~started_r;
  assign ge_peak    = ~(eq_in_r < high_r);
  assign lt_trough  = (eq_in_r < low_r);
  assign new_worst  = (drop_r > wdrop_r);
  // A day that runs backwards counts as a zero-length run.
  assign dur        = (day_in_r >= hday_r) ? (day_in_r - hday_r) : '0;
  assign longer     = (dur >= ldays_r);
  assign out_free   = ~out_valid_r | out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ddt_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = ddt_pkg::ST_EVAL;
      end
      ddt_pkg::ST_EVAL: begin
        if (first_item)     state_nxt = ddt_pkg::ST_FIN;
        else if (ge_peak)   state_nxt = ddt_pkg::ST_DUR;
        else if (lt_trough) state_nxt = ddt_pkg::ST_DROP;
        else                state_nxt = ddt_pkg::ST_FIN;
      end
      ddt_pkg::ST_DROP: begin
        state_nxt = new_worst ? ddt_pkg::ST_DIV : ddt_pkg::ST_DUR;
      end
      ddt_pkg::ST_DIV: begin
        if (div_done) state_nxt = ddt_pkg::ST_DUR;
      end
      ddt_pkg::ST_DUR: begin
        state_nxt = ddt_pkg::ST_FIN;
      end
      ddt_pkg::ST_FIN: begin
        if (out_free) state_nxt = ddt_pkg::ST_IDLE;
      end
      default: state_nxt = ddt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready   = 1'b0;
    do_init     = 1'b0;
    do_peak_run = 1'b0;
    do_low      = 1'b0;
    do_worst    = 1'b0;
    do_ratio    = 1'b0;
    do_dur      = 1'b0;
    do_out      = 1'b0;
    case (state_r)
      ddt_pkg::ST_IDLE: in_tready = 1'b1;
      ddt_pkg::ST_EVAL: begin
        do_init     = first_item;
        do_peak_run = ~first_item & ge_peak;
        do_low      = ~first_item & ~ge_peak & lt_trough;
      end
      ddt_pkg::ST_DROP: do_worst = new_worst;
      ddt_pkg::ST_DIV:  do_ratio = div_done;
      ddt_pkg::ST_DUR:  do_dur   = 1'b1;
      ddt_pkg::ST_FIN:  do_out   = out_free;
      default: ;
    endcase
  end

  assign accept = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ddt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (accept) begin
      start_in_r <= in_tuser;
      day_in_r   <= in_tdata[DW-1:0];
      eq_in_r    <= in_tdata[DW+VW-1:DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else if (do_init) begin
      started_r <= 1'b1;
    end
  end

  // Tracker records
  always_ff @(posedge clk) begin
    if (do_init) begin
      high_r   <= eq_in_r;
      low_r    <= eq_in_r;
      hday_r   <= day_in_r;
      wdrop_r  <= '0;
      wratio_r <= '0;
      wbeg_r   <= day_in_r;
      wend_r   <= day_in_r;
      ldays_r  <= '0;
      lbeg_r   <= day_in_r;
      lend_r   <= day_in_r;
    end
    if (do_peak_run) begin
      peak_case_r <= 1'b1;
    end
    if (do_low) begin
      // New trough: measure the drop and the peak magnitude for the divider.
      peak_case_r <= 1'b0;
      low_r       <= eq_in_r;
      drop_r      <= VW'(high_r - eq_in_r);
      mag_r       <= high_r[VW-1] ? VW'(-high_r) : VW'(high_r);
    end
    if (do_worst) begin
      wdrop_r <= drop_r;
      wbeg_r  <= hday_r;
      wend_r  <= day_in_r;
    end
    if (do_ratio) begin
      wratio_r <= div_ratio;
    end
    if (do_dur) begin
      // Measure the run against the old peak day, then move the peak on a new peak.
      if (longer) begin
        ldays_r <= dur;
        lbeg_r  <= hday_r;
        lend_r  <= day_in_r;
      end
      if (peak_case_r) begin
        high_r <= eq_in_r;
        low_r  <= eq_in_r;
        hday_r <= day_in_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_out) begin
      out_data_r <= {PADW'(0), hday_r, low_r, high_r, lend_r, lbeg_r, ldays_r,
                     wend_r, wbeg_r, wratio_r, wdrop_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ddt_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (do_worst),
    .drop  (drop_r),
    .mag   (mag_r),
    .done  (div_done),
    .ratio (div_ratio)
  );

  // Trough never rises above the peak once tracking has begun.
  assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> !(high_r < low_r))
    else $error("trough above peak");

  // An accepted item is evaluated on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ddt_pkg::ST_EVAL))
    else $error("accepted item not evaluated");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ddt_pkg::ST_DIV))
    else $error("divider finished outside its wait state");

endmodule
